FILE: hw/rtl/fbpa_pkg.sv
// shared types and constants for the fixed block pool allocator
`timescale 1ns / 1ps

package fbpa_pkg;

    localparam int MAX_BLOCKS_DEFAULT = 256;

    localparam int SIZE_W    = 16;
    localparam int ALIGN_W   = 4;
    localparam int ADDR_W    = 32;
    localparam int COUNT_W   = 9;
    localparam int INDEX_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int MASK_W    = 15;
    localparam int STRIDE_W  = 17;
    localparam int ROUND_W   = 17;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_ALIGN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_CNT  = 2'd3;

    // register reset values
    localparam logic [SIZE_W-1:0]  BLOCK_SIZE_RST = 16'd16;
    localparam logic [ALIGN_W-1:0] HEAP_ALIGN_RST = 4'd4;
    localparam logic [ADDR_W-1:0]  HEAP_BASE_RST  = 32'd0;
    localparam logic [COUNT_W-1:0] BLOCK_CNT_RST  = 9'd0;

    // operation codes
    localparam logic [1:0] FUNC_REBUILD = 2'd0;
    localparam logic [1:0] FUNC_ALLOC   = 2'd1;
    localparam logic [1:0] FUNC_FREE    = 2'd2;

    // request size handling
    localparam int SIZE_ZERO_AS  = 16;
    localparam int ROUND_MASK    = 15;
    localparam int ALIGN_MAX     = 12;
    localparam int ALIGN_DEFAULT = 4;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ALIGN = 2'd1,
        ST_SIZE  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef struct packed {
        logic capture;
        logic lookup;
    } calc_ctl_t;

    typedef struct packed {
        status_t             status;
        logic [INDEX_W-1:0]  alloc_index;
        logic [SIZE_W-1:0]   user_size;
        logic                addr_ok;
    } res_t;

endpackage

FILE: hw/rtl/fbpa_link_mem.sv
// next-link memory of the free list, one write port and one registered read port
`timescale 1ns / 1ps

module fbpa_link_mem #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEFAULT,
    localparam int IDX_W = (MAX_BLOCKS > 2) ? $clog2(MAX_BLOCKS) : 1,
    localparam int LINK_W = $clog2(MAX_BLOCKS + 1)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [IDX_W-1:0]  waddr,
    input  logic [LINK_W-1:0] wdata,
    input  logic [IDX_W-1:0]  raddr,
    output logic [LINK_W-1:0] rdata
);

    logic [LINK_W-1:0] link_mem [MAX_BLOCKS];
    logic [LINK_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            link_mem[waddr] <= wdata;
        end
        rdata_reg <= link_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/fbpa_addr_calc.sv
// block geometry and user address pipeline
`timescale 1ns / 1ps

module fbpa_addr_calc #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEFAULT,
    localparam int IDX_W = (MAX_BLOCKS > 2) ? $clog2(MAX_BLOCKS) : 1
) (
    input  logic                               clk,
    input  fbpa_pkg::calc_ctl_t                calc_ctl,
    input  logic [fbpa_pkg::SIZE_W-1:0]        blk_bytes,
    input  logic [fbpa_pkg::ALIGN_W-1:0]       heap_align_log2,
    input  logic [fbpa_pkg::ADDR_W-1:0]        heap_base,
    input  logic [IDX_W-1:0]                   head,
    output logic [fbpa_pkg::ADDR_W-1:0]        addr
);

    localparam int MW = fbpa_pkg::MASK_W;
    localparam int SW = fbpa_pkg::STRIDE_W;
    localparam int AW = fbpa_pkg::ADDR_W;

    logic [MW-1:0] mask;
    logic [MW-1:0] prefix_next;
    logic [SW-1:0] stride_next;
    logic [MW-1:0] start_low;
    logic [MW-1:0] pad_next;

    logic [MW-1:0] prefix_reg;
    logic [SW-1:0] stride_reg;
    logic [AW-1:0] part_reg;
    logic [MW-1:0] pad_reg;
    logic [AW-1:0] prod_reg;

    always_comb
    begin
        mask        = MW'((32'd1 << heap_align_log2) - 32'd1);
        // padding up to the alignment is the negated value under the mask
        prefix_next = (~blk_bytes[MW-1:0] + MW'(1)) & mask;
        stride_next = SW'(blk_bytes) + SW'(prefix_next);
        start_low   = heap_base[MW-1:0] + prefix_reg;
        pad_next    = (~start_low + MW'(1)) & mask;
    end

    always_ff @(posedge clk)
    begin
        if (calc_ctl.capture)
        begin
            prefix_reg <= prefix_next;
            stride_reg <= stride_next;
        end
        if (calc_ctl.lookup)
        begin
            part_reg <= heap_base + AW'(prefix_reg);
            pad_reg  <= pad_next;
            prod_reg <= AW'(head) * AW'(stride_reg);
        end
    end

    assign addr = part_reg + AW'(pad_reg) + prod_reg;

endmodule

FILE: hw/rtl/fbpa_ctrl.sv
// free list sequencer: head register, rebuild walk, allocate and free
`timescale 1ns / 1ps

module fbpa_ctrl #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEFAULT,
    localparam int IDX_W = (MAX_BLOCKS > 2) ? $clog2(MAX_BLOCKS) : 1,
    localparam int LINK_W = $clog2(MAX_BLOCKS + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         func,
    input  logic [fbpa_pkg::SIZE_W-1:0]        req_size,
    input  logic [fbpa_pkg::ALIGN_W-1:0]       req_align_log2,
    input  logic [fbpa_pkg::INDEX_W-1:0]       block_index,
    input  logic [fbpa_pkg::SIZE_W-1:0]        blk_bytes,
    input  logic [fbpa_pkg::ALIGN_W-1:0]       heap_align_log2,
    input  logic [fbpa_pkg::COUNT_W-1:0]       pool_blocks,
    input  logic                               out_free,
    output logic                               mem_we,
    output logic [IDX_W-1:0]                   mem_waddr,
    output logic [LINK_W-1:0]                  mem_wdata,
    output logic [IDX_W-1:0]                   mem_raddr,
    input  logic [LINK_W-1:0]                  mem_rdata,
    output fbpa_pkg::calc_ctl_t                calc_ctl,
    output logic [IDX_W-1:0]                   alloc_head,
    output logic                               res_valid,
    output fbpa_pkg::res_t                     res
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_BUILD  = 5'b00010,
        S_LOOKUP = 5'b00100,
        S_ADDR   = 5'b01000,
        S_REPLY  = 5'b10000
    } state_t;

    localparam logic [LINK_W-1:0] LINK_END = LINK_W'(MAX_BLOCKS);

    state_t                        state_reg, state_next;
    logic [IDX_W-1:0]              head_reg, head_next;
    logic                          empty_reg, empty_next;
    fbpa_pkg::status_t             status_reg, status_next;
    logic [IDX_W-1:0]              h_reg, h_next;
    logic [fbpa_pkg::SIZE_W-1:0]   size_reg, size_next;
    logic [IDX_W-1:0]              build_idx_reg, build_idx_next;
    logic [IDX_W-1:0]              build_last_reg, build_last_next;

    logic                          accept;
    logic [fbpa_pkg::SIZE_W-1:0]   size_eff;
    logic [fbpa_pkg::ROUND_W-1:0]  rounded;
    logic [fbpa_pkg::ALIGN_W-1:0]  align_eff;
    logic [31:0]                   cnt;
    logic                          free_ok;

    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign mem_raddr  = head_reg;
    assign alloc_head = h_reg;

    always_comb
    begin
        size_eff  = (req_size == '0) ? fbpa_pkg::SIZE_W'(fbpa_pkg::SIZE_ZERO_AS) : req_size;
        rounded   = (fbpa_pkg::ROUND_W'(size_eff) + fbpa_pkg::ROUND_W'(fbpa_pkg::ROUND_MASK))
                    & ~fbpa_pkg::ROUND_W'(fbpa_pkg::ROUND_MASK);
        align_eff = (req_align_log2 > fbpa_pkg::ALIGN_W'(fbpa_pkg::ALIGN_MAX))
                    ? fbpa_pkg::ALIGN_W'(fbpa_pkg::ALIGN_DEFAULT) : req_align_log2;
        cnt       = (32'(pool_blocks) > 32'(MAX_BLOCKS)) ? 32'(MAX_BLOCKS) : 32'(pool_blocks);
        free_ok   = 32'(block_index) < 32'(MAX_BLOCKS);
    end

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        empty_next      = empty_reg;
        status_next     = status_reg;
        h_next          = h_reg;
        size_next       = size_reg;
        build_idx_next  = build_idx_reg;
        build_last_next = build_last_reg;
        mem_we          = 1'b0;
        mem_waddr       = build_idx_reg;
        mem_wdata       = LINK_END;
        calc_ctl        = '0;
        res_valid       = 1'b0;
        res             = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = fbpa_pkg::ST_OK;
                    state_next  = S_REPLY;
                    unique case (func)
                        fbpa_pkg::FUNC_REBUILD:
                        begin
                            empty_next = 1'b1;
                            head_next  = '0;
                            if (cnt != 32'd0)
                            begin
                                build_idx_next  = '0;
                                build_last_next = IDX_W'(cnt - 32'd1);
                                state_next      = S_BUILD;
                            end
                        end
                        fbpa_pkg::FUNC_ALLOC:
                        begin
                            h_next    = head_reg;
                            size_next = rounded[fbpa_pkg::SIZE_W-1:0];
                            if (align_eff > heap_align_log2)
                            begin
                                status_next = fbpa_pkg::ST_ALIGN;
                            end
                            else if (rounded > fbpa_pkg::ROUND_W'(blk_bytes))
                            begin
                                status_next = fbpa_pkg::ST_SIZE;
                            end
                            else if (empty_reg)
                            begin
                                status_next = fbpa_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                calc_ctl.capture = 1'b1;
                                state_next       = S_LOOKUP;
                            end
                        end
                        fbpa_pkg::FUNC_FREE:
                        begin
                            if (free_ok)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = IDX_W'(32'(block_index));
                                mem_wdata  = empty_reg ? LINK_END : LINK_W'(head_reg);
                                head_next  = IDX_W'(32'(block_index));
                                empty_next = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_BUILD:
            begin
                mem_we    = 1'b1;
                mem_waddr = build_idx_reg;
                mem_wdata = (build_idx_reg == '0)
                            ? LINK_END : (LINK_W'(build_idx_reg) - LINK_W'(1));
                if (build_idx_reg == build_last_reg)
                begin
                    head_next  = build_idx_reg;
                    empty_next = 1'b0;
                    state_next = S_REPLY;
                end
                else
                begin
                    build_idx_next = build_idx_reg + IDX_W'(1);
                end
            end
            S_LOOKUP:
            begin
                calc_ctl.lookup = 1'b1;
                if (mem_rdata >= LINK_END)
                begin
                    empty_next = 1'b1;
                end
                else
                begin
                    head_next = IDX_W'(mem_rdata);
                end
                state_next = S_ADDR;
            end
            S_ADDR:
            begin
                res.status      = fbpa_pkg::ST_OK;
                res.alloc_index = fbpa_pkg::INDEX_W'(h_reg);
                res.user_size   = size_reg;
                res.addr_ok     = 1'b1;
                if (out_free)
                begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_REPLY:
            begin
                res.status = status_reg;
                if (out_free)
                begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            empty_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            empty_reg <= empty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg     <= status_next;
        h_reg          <= h_next;
        size_reg       <= size_next;
        build_idx_reg  <= build_idx_next;
        build_last_reg <= build_last_next;
    end

`ifndef SYNTHESIS
    a_lookup_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOKUP) |-> $past(state_reg == S_IDLE))
        else $error("lookup not preceded by an accepted allocate");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_IDLE || state_reg == S_BUILD))
        else $error("link write outside free or rebuild");

    a_build_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BUILD) |-> (build_idx_reg <= build_last_reg))
        else $error("rebuild walk past last block");

    a_result_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> (state_reg == S_IDLE))
        else $error("sequencer stuck after result transaction");

    a_alloc_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        calc_ctl.capture |-> !empty_reg)
        else $error("allocate started on an empty list");
`endif

endmodule

FILE: hw/rtl/fixed_block_pool_allocator_unit.sv
// top level of the fixed block pool allocator: registers, sequencer, memory and result stage
//
// Input channel (in_valid / in_stall) carries one request transaction: func selects a rebuild
// of the free list, an allocation or a free. Output channel (out_valid / out_stall) returns one
// result transaction per request with status, index, user address and rounded size.
// Configuration is a write port (cfg_we, cfg_index, cfg_data); the user must see that it is
// written only while idle; the block does not enforce it. From acceptance to result valid:
// free, failed allocate and the unused code pass the reply state; a successful allocate
// reads the link memory and multiplies, then sums the address; a rebuild writes one link per
// block, then passes the reply state. Only one request is in flight; a new request is taken
// as soon as the previous result sits in the output register, even if the receiver still
// stalls it. When out_stall is high the result holds; a finished result waiting for a full
// output register keeps the sequencer in place and in_stall high. Reset clears the registers
// to their defaults and empties the free list; the link memory needs no clearing pass, a
// rebuild writes every entry it later reads.
`timescale 1ns / 1ps

module fixed_block_pool_allocator_unit #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           func,
    input  logic [fbpa_pkg::SIZE_W-1:0]          req_size,
    input  logic [fbpa_pkg::ALIGN_W-1:0]         req_align_log2,
    input  logic [fbpa_pkg::INDEX_W-1:0]         block_index,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [1:0]                           status,
    output logic [fbpa_pkg::INDEX_W-1:0]         alloc_index,
    output logic [fbpa_pkg::ADDR_W-1:0]          alloc_address,
    output logic [fbpa_pkg::SIZE_W-1:0]          user_size,
    input  logic                                 cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fbpa_pkg::ADDR_W-1:0]          cfg_data
);

    localparam int IDX_W = (MAX_BLOCKS > 2) ? $clog2(MAX_BLOCKS) : 1;
    localparam int LINK_W = $clog2(MAX_BLOCKS + 1);

    logic [fbpa_pkg::SIZE_W-1:0]  blk_bytes_reg;
    logic [fbpa_pkg::ALIGN_W-1:0] heap_align_reg;
    logic [fbpa_pkg::ADDR_W-1:0]  heap_base_reg;
    logic [fbpa_pkg::COUNT_W-1:0] block_cnt_reg;

    logic                         out_valid_reg;
    logic [1:0]                   status_reg;
    logic [fbpa_pkg::INDEX_W-1:0] alloc_index_reg;
    logic [fbpa_pkg::ADDR_W-1:0]  alloc_address_reg;
    logic [fbpa_pkg::SIZE_W-1:0]  user_size_reg;

    logic                         in_ready;
    logic                         out_free;
    logic                         mem_we;
    logic [IDX_W-1:0]             mem_waddr;
    logic [LINK_W-1:0]            mem_wdata;
    logic [IDX_W-1:0]             mem_raddr;
    logic [LINK_W-1:0]            mem_rdata;
    fbpa_pkg::calc_ctl_t          calc_ctl;
    logic [IDX_W-1:0]             alloc_head;
    logic                         res_valid;
    fbpa_pkg::res_t               res;
    logic [fbpa_pkg::ADDR_W-1:0]  calc_addr;

    assign in_stall = !in_ready;
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_bytes_reg  <= fbpa_pkg::BLOCK_SIZE_RST;
            heap_align_reg <= fbpa_pkg::HEAP_ALIGN_RST;
            heap_base_reg  <= fbpa_pkg::HEAP_BASE_RST;
            block_cnt_reg  <= fbpa_pkg::BLOCK_CNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fbpa_pkg::CFG_BLOCK_SIZE: blk_bytes_reg  <= cfg_data[fbpa_pkg::SIZE_W-1:0];
                fbpa_pkg::CFG_HEAP_ALIGN: heap_align_reg <= cfg_data[fbpa_pkg::ALIGN_W-1:0];
                fbpa_pkg::CFG_HEAP_BASE:  heap_base_reg  <= cfg_data;
                fbpa_pkg::CFG_BLOCK_CNT:  block_cnt_reg  <= cfg_data[fbpa_pkg::COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    fbpa_link_mem #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_link_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    fbpa_addr_calc #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_addr_calc (
        .clk             (clk),
        .calc_ctl        (calc_ctl),
        .blk_bytes       (blk_bytes_reg),
        .heap_align_log2 (heap_align_reg),
        .heap_base       (heap_base_reg),
        .head            (alloc_head),
        .addr            (calc_addr)
    );

    fbpa_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .req_size        (req_size),
        .req_align_log2  (req_align_log2),
        .block_index     (block_index),
        .blk_bytes       (blk_bytes_reg),
        .heap_align_log2 (heap_align_reg),
        .pool_blocks     (block_cnt_reg),
        .out_free        (out_free),
        .mem_we          (mem_we),
        .mem_waddr       (mem_waddr),
        .mem_wdata       (mem_wdata),
        .mem_raddr       (mem_raddr),
        .mem_rdata       (mem_rdata),
        .calc_ctl        (calc_ctl),
        .alloc_head      (alloc_head),
        .res_valid       (res_valid),
        .res             (res)
    );

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            status_reg        <= res.status;
            alloc_index_reg   <= res.alloc_index;
            alloc_address_reg <= res.addr_ok ? calc_addr : '0;
            user_size_reg     <= res.user_size;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign alloc_index   = alloc_index_reg;
    assign alloc_address = alloc_address_reg;
    assign user_size     = user_size_reg;

endmodule
